/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by nvmeq_step and nvmeq_res_fifo
// ----------------------------------------------------------------------------
// define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("invariant violated");

// antecedent this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sequence check violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/nvmeq_pkg.sv */
// ----------------------------------------------------------------------------
// nvmeq_pkg
// types, codes and constants shared by the i/o queue engine files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nvmeq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PAGE_BYTES  = 4096;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int DB_W        = 5;
  localparam int TICK_W      = 17;
  // chunk of up to 16 sectors shifted by up to 15
  localparam int BYTES_W     = 20;
  localparam int CHUNK_MAX   = 16;

  // input functions
  localparam logic [1:0] FUNC_REQ   = 2'd0;
  localparam logic [1:0] FUNC_CQE   = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_FATAL = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DB   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // command opcodes
  localparam logic [1:0] OP_FLUSH = 2'h0;
  localparam logic [1:0] OP_WRITE = 2'h1;
  localparam logic [1:0] OP_READ  = 2'h2;

  // register indexes
  localparam logic [2:0] REG_SECTOR_SHIFT = 3'd0;
  localparam logic [2:0] REG_MAX_CHUNK    = 3'd1;
  localparam logic [2:0] REG_NSID         = 3'd2;
  localparam logic [2:0] REG_BUF_BASE     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT      = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_DATA  = 3'b010,
    MODE_FLUSH = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] lba;
    logic [31:0] count;
    logic        is_write;
    logic [15:0] cq_status;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  opcode;
    logic [15:0] cid;
    logic [31:0] nsid;
    logic [63:0] start_lba;
    logic [3:0]  blocks_minus_one;
    logic [63:0] prp1;
    logic [63:0] prp2;
    logic [4:0]  doorbell_value;
    logic        ok;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  sector_shift;
    logic [4:0]  max_chunk_sectors;
    logic [31:0] ns_id;
    logic [63:0] buffer_base;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // queue index to doorbell width, zero-extended or truncated
  function automatic logic [DB_W-1:0] db_value(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W+DB_W-1:0] wide;
    wide = {{DB_W{1'b0}}, idx};
    return wide[DB_W-1:0];
  endfunction

  // queue index advance with wrap
  function automatic logic [QIDX_W-1:0] qidx_inc(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + QIDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/nvmeq_step.sv */
// ----------------------------------------------------------------------------
// nvmeq_step
// queue pair state and the results of one word, in a single pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nvmeq_step
  import nvmeq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_word_t  item,
  input  wire cfg_t      cfg,
  output out_word_t      res0,
  output out_word_t      res1,
  output logic [1:0]     n_res
);

  logic [QIDX_W-1:0] sub_tail_r, sub_tail_nxt;
  logic [QIDX_W-1:0] comp_head_r, comp_head_nxt;
  logic              phase_r, phase_nxt;
  logic [15:0]       next_id_r, next_id_nxt;
  mode_t             mode_r, mode_nxt;
  logic [63:0]       rem_lba_r, rem_lba_nxt;
  logic [31:0]       rem_cnt_r, rem_cnt_nxt;
  logic              wr_flag_r, wr_flag_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;

  logic [63:0]       adv_lba;
  logic [31:0]       adv_cnt;
  logic              adv_wr;
  logic [4:0]        lim;
  logic [4:0]        chunk;
  logic [BYTES_W-1:0] bytes;
  logic [QIDX_W-1:0] tail_inc;
  logic [QIDX_W-1:0] head_inc;
  logic [TICK_W-1:0] elapsed_inc;
  out_word_t         adv_res;
  out_word_t         done_res;
  logic              take_adv;
  logic              adv_issues;

  // advance source: a new request or what remains of the current one
  always_comb begin
    if (item.func == FUNC_REQ) begin
      adv_lba = item.lba;
      adv_cnt = item.count;
      adv_wr  = item.is_write;
    end else begin
      adv_lba = rem_lba_r;
      adv_cnt = rem_cnt_r;
      adv_wr  = wr_flag_r;
    end
  end

  always_comb begin
    if (cfg.max_chunk_sectors == 5'd0) begin
      lim = 5'd1;
    end else if (cfg.max_chunk_sectors > 5'(CHUNK_MAX)) begin
      lim = 5'(CHUNK_MAX);
    end else begin
      lim = cfg.max_chunk_sectors;
    end
    chunk = (adv_cnt < {27'd0, lim}) ? adv_cnt[4:0] : lim;
    bytes = BYTES_W'(chunk) << cfg.sector_shift;
  end

  assign tail_inc    = qidx_inc(sub_tail_r);
  assign head_inc    = qidx_inc(comp_head_r);
  assign elapsed_inc = (elapsed_r == {TICK_W{1'b1}}) ? elapsed_r
                                                       : elapsed_r + TICK_W'(1);
  assign adv_issues  = (adv_cnt != 32'd0) || adv_wr;

  // result of an advance: data command, flush, or done
  always_comb begin
    adv_res = '0;
    if (adv_cnt == 32'd0 && !adv_wr) begin
      adv_res.kind = KIND_DONE;
      adv_res.ok   = 1'b1;
    end else begin
      adv_res.kind           = KIND_CMD;
      adv_res.cid            = next_id_r;
      adv_res.nsid           = cfg.ns_id;
      adv_res.doorbell_value = db_value(tail_inc);
      if (adv_cnt == 32'd0) begin
        adv_res.opcode = OP_FLUSH;
      end else begin
        adv_res.opcode           = adv_wr ? OP_WRITE : OP_READ;
        adv_res.start_lba        = adv_lba;
        adv_res.blocks_minus_one = 4'(chunk - 5'd1);
        adv_res.prp1             = cfg.buffer_base;
        adv_res.prp2             = (bytes > BYTES_W'(PAGE_BYTES))
                                   ? cfg.buffer_base + 64'(PAGE_BYTES) : 64'd0;
      end
    end
  end

  always_comb begin
    sub_tail_nxt  = sub_tail_r;
    comp_head_nxt = comp_head_r;
    phase_nxt     = phase_r;
    next_id_nxt   = next_id_r;
    mode_nxt      = mode_r;
    rem_lba_nxt   = rem_lba_r;
    rem_cnt_nxt   = rem_cnt_r;
    wr_flag_nxt   = wr_flag_r;
    elapsed_nxt   = elapsed_r;
    res0          = '0;
    res1          = '0;
    n_res         = 2'd0;
    take_adv      = 1'b0;
    done_res      = '0;
    done_res.kind = KIND_DONE;

    if (fire) begin
      unique case (item.func)
        FUNC_REQ: begin
          if (mode_r == MODE_IDLE) begin
            wr_flag_nxt = item.is_write;
            take_adv    = 1'b1;
            res0        = adv_res;
            n_res       = 2'd1;
          end
        end
        FUNC_CQE: begin
          if (mode_r != MODE_IDLE && item.cq_status[0] == phase_r) begin
            comp_head_nxt = head_inc;
            if (head_inc == '0) begin
              phase_nxt = ~phase_r;
            end
            res0.kind           = KIND_DB;
            res0.doorbell_value = db_value(head_inc);
            n_res               = 2'd2;
            if (mode_r == MODE_FLUSH) begin
              res1     = done_res;
              res1.ok  = 1'b1;
              mode_nxt = MODE_IDLE;
            end else if (item.cq_status[15:1] != 15'd0) begin
              res1     = done_res;
              mode_nxt = MODE_IDLE;
            end else begin
              res1     = adv_res;
              take_adv = 1'b1;
            end
          end
        end
        FUNC_TICK, FUNC_FATAL: begin
          if (mode_r != MODE_IDLE) begin
            if (item.func == FUNC_TICK) begin
              elapsed_nxt = elapsed_inc;
            end
            if (item.func == FUNC_FATAL || elapsed_inc > {1'b0, cfg.timeout_ticks}) begin
              res0     = done_res;
              res0.ok  = (mode_r == MODE_FLUSH);
              mode_nxt = MODE_IDLE;
              n_res    = 2'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // side effects of an advance
    if (take_adv) begin
      if (adv_cnt == 32'd0) begin
        mode_nxt = adv_wr ? MODE_FLUSH : MODE_IDLE;
      end else begin
        mode_nxt    = MODE_DATA;
        rem_lba_nxt = adv_lba + {59'd0, chunk};
        rem_cnt_nxt = adv_cnt - {27'd0, chunk};
      end
      if (item.func == FUNC_REQ) begin
        if (adv_cnt == 32'd0) begin
          rem_lba_nxt = item.lba;
          rem_cnt_nxt = 32'd0;
        end
      end
      if (adv_issues) begin
        next_id_nxt  = next_id_r + 16'd1;
        sub_tail_nxt = tail_inc;
        elapsed_nxt  = '0;
      end
    end

    // mark the final result of the word
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_tail_r  <= '0;
      comp_head_r <= '0;
      phase_r     <= 1'b1;
      next_id_r   <= '0;
      mode_r      <= MODE_IDLE;
      rem_lba_r   <= '0;
      rem_cnt_r   <= '0;
      wr_flag_r   <= 1'b0;
      elapsed_r   <= '0;
    end else begin
      sub_tail_r  <= sub_tail_nxt;
      comp_head_r <= comp_head_nxt;
      phase_r     <= phase_nxt;
      next_id_r   <= next_id_nxt;
      mode_r      <= mode_nxt;
      rem_lba_r   <= rem_lba_nxt;
      rem_cnt_r   <= rem_cnt_nxt;
      wr_flag_r   <= wr_flag_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

  // a request while busy yields nothing
  `ASSERT_ALWAYS(a_busy_req_silent, clk, rst_n,
    !(fire && item.func == FUNC_REQ && mode_r != MODE_IDLE) || n_res == 2'd0)
  // completions, ticks and fatal flags while idle yield nothing
  `ASSERT_ALWAYS(a_idle_event_silent, clk, rst_n,
    !(fire && item.func != FUNC_REQ && mode_r == MODE_IDLE) || n_res == 2'd0)
  // every issued command moves the id on by one
  `ASSERT_NEXT(a_id_step, clk, rst_n, fire && take_adv && adv_issues,
    next_id_r == $past(next_id_r) + 16'd1)

endmodule

`default_nettype wire

/* sv/nvmeq_res_fifo.sv */
// ----------------------------------------------------------------------------
// nvmeq_res_fifo
// four-word result queue, takes up to two words a cycle, gives one while the sink is ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nvmeq_res_fifo
  import nvmeq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] push_n,
  input  wire out_word_t push0,
  input  wire out_word_t push1,
  output logic           room2,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = 2;

  out_word_t           ent_r [RES_DEPTH];
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [PTR_W-1:0]    rp_r, rp_nxt;
  logic [PTR_W:0]      count_r, count_nxt;
  logic [PTR_W-1:0]    wp_plus1;
  logic                pop;

  assign wp_plus1  = wp_r + PTR_W'(1);
  assign out_valid = (count_r != '0);
  assign out_word  = ent_r[rp_r];
  assign room2     = (count_r <= (PTR_W+1)'(RES_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt    = wp_r + PTR_W'(push_n);
    rp_nxt    = pop ? rp_r + PTR_W'(1) : rp_r;
    count_nxt = count_r + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      if (push_n != 2'd0 && wp_r == PTR_W'(i)) begin
        ent_r[i] <= push0;
      end else if (push_n == 2'd2 && wp_plus1 == PTR_W'(i)) begin
        ent_r[i] <= push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_ALWAYS(a_no_overfill, clk, rst_n, count_r <= (PTR_W+1)'(RES_DEPTH))
  `ASSERT_ALWAYS(a_push_has_room, clk, rst_n, push_n == 2'd0 || room2)
  `ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && push_n == 2'd0,
    count_r == $past(count_r) - (PTR_W+1)'(1))

endmodule

`default_nettype wire

/* sv/nvme_io_queue_engine.sv */
// ----------------------------------------------------------------------------
// nvme_io_queue_engine
// path: a word taken at in_ goes through the input register, then the
//   result queue, before its first result can be taken at out_
// throughput: one word per cycle while the four-word result queue holds at
//   most two words; a two-result word gives two words at the output port
// reset: rst_n synchronous, clears queue indexes, ids, mode and result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvme_io_queue_engine
  import nvmeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_word,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_word,
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  // configuration registers
  cfg_t       cfg_r;

  // input register in front of the step logic
  logic       in_valid_r;
  in_word_t   in_word_r;

  logic       room2;
  logic       fire;
  out_word_t  res0;
  out_word_t  res1;
  logic [1:0] n_res;

  // the step runs once the queue can take both possible results
  assign fire     = in_valid_r && room2;
  // the input register frees as its word is evaluated
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_word;
    end
  end

  // register writes, unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sector_shift      <= 4'd9;
      cfg_r.max_chunk_sectors <= 5'd16;
      cfg_r.ns_id             <= 32'd1;
      cfg_r.buffer_base       <= 64'd0;
      cfg_r.timeout_ticks     <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECTOR_SHIFT: cfg_r.sector_shift      <= cfg_wdata[3:0];
        REG_MAX_CHUNK:    cfg_r.max_chunk_sectors <= cfg_wdata[4:0];
        REG_NSID:         cfg_r.ns_id             <= cfg_wdata[31:0];
        REG_BUF_BASE:     cfg_r.buffer_base       <= cfg_wdata;
        REG_TIMEOUT:      cfg_r.timeout_ticks     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // queue pair state and per-word results
  nvmeq_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_word_r),
    .cfg   (cfg_r),
    .res0  (res0),
    .res1  (res1),
    .n_res (n_res)
  );

  // result queue acts as the output register and decouples a stalled sink
  nvmeq_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (fire ? n_res : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives the i/o queue engine with block requests, completion entries, ticks
// and fatal flags through its valid/ready channels; an in-house predictor of
// the queue pair works out every command, doorbell and done word, and each
// delivered word is compared field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import nvmeq_pkg::*;

  // row tags of the directed table
  localparam int PREDICT    = -1;  // expected words come from the predictor
  localparam int NO_RESULT  = 0;   // typed in: the word causes nothing
  localparam int ONE_RESULT = 1;   // typed in: exactly one word, given in the row

  localparam int TICK_SAT = (1 << TICK_W) - 1;

  typedef struct {
    in_word_t  word;
    int        pinned;
    out_word_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_word_t out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  nvme_io_queue_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor copy of the registers and the queue pair state
  // --------------------------------------------------------------------------
  logic [3:0]        shift_reg;
  logic [4:0]        chunk_reg;
  logic [31:0]       nsid_reg;
  logic [63:0]       base_reg;
  logic [15:0]       timeout_reg;

  int                sq_tail;
  int                cq_head;
  logic              want_phase;
  logic [15:0]       next_cid;
  mode_t             eng_mode;
  logic [63:0]       left_lba;
  logic [31:0]       left_count;
  logic              writing;
  logic [TICK_W-1:0] ticks_seen;

  // words worked out for the latest accepted input word
  out_word_t step_res [2];
  bit        step_ignored;

  // words still owed by the engine, oldest first
  out_word_t pending_words [$];

  // run bookkeeping
  int  mismatches;
  int  words_in;
  int  busy_words;
  int  settings_used;
  int  n_cmd, n_flush, n_db, n_done, n_failed;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  int  rx_hold = 0;

  task automatic reset_model();
    shift_reg   = 4'd9;
    chunk_reg   = 5'd16;
    nsid_reg    = 32'd1;
    base_reg    = '0;
    timeout_reg = 16'd5000;
    sq_tail     = 0;
    cq_head     = 0;
    want_phase  = 1'b1;
    next_cid    = '0;
    eng_mode    = MODE_IDLE;
    left_lba    = '0;
    left_count  = '0;
    writing     = 1'b0;
    ticks_seen  = '0;
  endtask

  // chunk register with out-of-range values folded into 1..16
  function automatic int unsigned chunk_limit();
    int unsigned lim;
    lim = chunk_reg;
    if (lim == 0) lim = 1;
    if (lim > CHUNK_MAX) lim = CHUNK_MAX;
    return lim;
  endfunction

  function automatic out_word_t done_word(input bit ok);
    out_word_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.ok = ok;
    return r;
  endfunction

  // builds one submission entry and moves the tail and the id on
  function automatic out_word_t issue_cmd(input logic [1:0] op, input logic [63:0] lba,
                                          input int unsigned chunk);
    out_word_t   r;
    logic [19:0] nbytes;
    r = '0;
    r.kind = KIND_CMD;
    r.opcode = op;
    r.cid = next_cid;
    next_cid = next_cid + 16'd1;
    r.nsid = nsid_reg;
    if (op != OP_FLUSH) begin
      nbytes = 20'(chunk) << shift_reg;
      r.start_lba = lba;
      r.blocks_minus_one = 4'(chunk - 1);
      r.prp1 = base_reg;
      // second page pointer only once the chunk spills past one page
      r.prp2 = (nbytes > PAGE_BYTES) ? base_reg + 64'(PAGE_BYTES) : '0;
    end
    sq_tail = (sq_tail + 1) % QUEUE_DEPTH;
    r.doorbell_value = DB_W'(sq_tail);
    ticks_seen = '0;
    return r;
  endfunction

  // next data chunk, else the closing flush of a write, else done
  function automatic out_word_t next_chunk();
    int unsigned chunk;
    logic [63:0] lba;
    if (left_count == 0) begin
      if (writing) begin
        eng_mode = MODE_FLUSH;
        return issue_cmd(OP_FLUSH, '0, 0);
      end
      eng_mode = MODE_IDLE;
      return done_word(1'b1);
    end
    chunk = (left_count < chunk_limit()) ? left_count : chunk_limit();
    lba = left_lba;
    left_lba = left_lba + 64'(chunk);
    left_count = left_count - chunk;
    eng_mode = MODE_DATA;
    return issue_cmd(writing ? OP_WRITE : OP_READ, lba, chunk);
  endfunction

  // predicts the words caused by one accepted input word
  function automatic int engine_step(input in_word_t w);
    int n;
    n = 0;
    step_ignored = 1'b0;
    case (w.func)
      FUNC_REQ: begin
        if (eng_mode != MODE_IDLE) begin
          step_ignored = 1'b1;
        end else begin
          left_lba = w.lba;
          left_count = w.count;
          writing = w.is_write;
          step_res[0] = next_chunk();
          n = 1;
        end
      end
      FUNC_CQE: begin
        if (eng_mode == MODE_IDLE || w.cq_status[0] != want_phase) begin
          step_ignored = 1'b1;
        end else begin
          cq_head = (cq_head + 1) % QUEUE_DEPTH;
          if (cq_head == 0) want_phase = ~want_phase;
          step_res[0] = '0;
          step_res[0].kind = KIND_DB;
          step_res[0].doorbell_value = DB_W'(cq_head);
          // flush status is ignored; a data error ends the request
          if (eng_mode == MODE_FLUSH) begin
            step_res[1] = done_word(1'b1);
            eng_mode = MODE_IDLE;
          end else if (w.cq_status[15:1] != '0) begin
            step_res[1] = done_word(1'b0);
            eng_mode = MODE_IDLE;
          end else begin
            step_res[1] = next_chunk();
          end
          n = 2;
        end
      end
      default: begin
        if (eng_mode == MODE_IDLE) begin
          step_ignored = 1'b1;
        end else begin
          if (w.func == FUNC_TICK && ticks_seen != TICK_W'(TICK_SAT))
            ticks_seen = ticks_seen + 1'b1;
          if (w.func == FUNC_FATAL || ticks_seen > {1'b0, timeout_reg}) begin
            // abort: a flush that never finished still counts as success
            step_res[0] = done_word(eng_mode == MODE_FLUSH);
            eng_mode = MODE_IDLE;
            n = 1;
          end
        end
      end
    endcase
    if (n > 0) step_res[n-1].last = 1'b1;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // random stimulus, shaped by where the engine currently stands
  // --------------------------------------------------------------------------
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.func = FUNC_REQ;
    w.lba = {$urandom, $urandom};
    w.count = $urandom;
    w.is_write = 1'($urandom);
    w.cq_status = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (eng_mode == MODE_IDLE) begin
      if (pick < 85) begin
        // mostly short requests so that they run to the end
        case ($urandom_range(0, 9))
          0:       w.count = '0;
          1:       w.count = $urandom;
          2, 3:    w.count = $urandom_range(1, 60);
          default: w.count = $urandom_range(1, 3 * chunk_limit());
        endcase
        if ($urandom_range(0, 3) == 0)
          w.lba = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      end else begin
        // noise while idle
        w.func = 2'($urandom_range(1, 3));
      end
    end else if (pick < 70) begin
      w.func = FUNC_CQE;
      w.cq_status = {15'd0, want_phase};
    end else if (pick < 76) begin
      // error status with a matching phase
      w.func = FUNC_CQE;
      w.cq_status[0] = want_phase;
      if (w.cq_status[15:1] == '0) w.cq_status[15:1] = 15'd1;
    end else if (pick < 82) begin
      // stale entry
      w.func = FUNC_CQE;
      w.cq_status[0] = ~want_phase;
    end else if (pick < 92) begin
      w.func = FUNC_TICK;
    end else if (pick < 95) begin
      w.func = FUNC_FATAL;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %h, want %h at %0t ns", what, got, want, $time);
  endtask

  task automatic compare_word(input out_word_t got, input out_word_t want);
    if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
    if (got.opcode !== want.opcode) flag_mismatch("opcode", got.opcode, want.opcode);
    if (got.cid !== want.cid)
      flag_mismatch("cid", got.cid, want.cid);
    if (got.nsid !== want.nsid) flag_mismatch("nsid", got.nsid, want.nsid);
    if (got.start_lba !== want.start_lba)
      flag_mismatch("start_lba", got.start_lba, want.start_lba);
    if (got.blocks_minus_one !== want.blocks_minus_one)
      flag_mismatch("blocks_minus_one", got.blocks_minus_one, want.blocks_minus_one);
    if (got.prp1 !== want.prp1) flag_mismatch("prp1", got.prp1, want.prp1);
    if (got.prp2 !== want.prp2) flag_mismatch("prp2", got.prp2, want.prp2);
    if (got.doorbell_value !== want.doorbell_value)
      flag_mismatch("doorbell_value", got.doorbell_value, want.doorbell_value);
    if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
    if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
  endtask

  // result side: sampled on the rising edge, before the engine updates
  out_word_t owed;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("word with nothing owed, kind", out_word.kind, '0);
      end else begin
        owed = pending_words.pop_front();
        compare_word(out_word, owed);
        case (owed.kind)
          KIND_CMD: begin
            n_cmd++;
            if (owed.opcode == OP_FLUSH) n_flush++;
          end
          KIND_DB: n_db++;
          default: begin
            n_done++;
            if (!owed.ok) n_failed++;
          end
        endcase
      end
    end
  end

  // receiver holds out_ready low in random bursts while stalls are on
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // one input word, with an optional gap in front; returns once accepted
  task automatic send_word(input in_word_t w, input int pinned, input out_word_t want);
    int gap;
    int n;
    gap = (tx_gaps_on && $urandom_range(0, 6) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    n = engine_step(w);
    words_in++;
    if (!step_ignored) busy_words++;
    if (pinned == PREDICT) begin
      for (int k = 0; k < n; k++) pending_words.push_back(step_res[k]);
    end else if (pinned == ONE_RESULT) begin
      pending_words.push_back(want);
    end
  endtask

  // hold the sender until everything owed has come out, then let the
  // pipeline empty of words that cause nothing
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SECTOR_SHIFT: shift_reg = value[3:0];
      REG_MAX_CHUNK:    chunk_reg = value[4:0];
      REG_NSID:         nsid_reg = value[31:0];
      REG_BUF_BASE:     base_reg = value;
      REG_TIMEOUT:      timeout_reg = value[15:0];
      default: ;
    endcase
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] f, input logic [63:0] lba,
                                      input logic [31:0] cnt, input bit wr,
                                      input logic [15:0] st, input int pinned,
                                      input out_word_t want);
    dir_row_t r;
    r.word.func = f;
    r.word.lba = lba;
    r.word.count = cnt;
    r.word.is_write = wr;
    r.word.cq_status = st;
    r.pinned = pinned;
    r.want = want;
    if (pinned == ONE_RESULT) r.want.last = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t  dir_rows [$];
    cfg_t      c;
    out_word_t first_cmd;
    int        target;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    reset_model();

    // first read after reset: id 0, tail 1, three 512 byte sectors, no prp2
    first_cmd = '0;
    first_cmd.kind = KIND_CMD;
    first_cmd.opcode = OP_READ;
    first_cmd.nsid = 32'd1;
    first_cmd.start_lba = 64'd5;
    first_cmd.blocks_minus_one = 4'd2;
    first_cmd.doorbell_value = 5'd1;

    // directed table, run with the register values from reset
    // events while idle are dropped
    dir_rows.push_back(mk_row(FUNC_TICK, '0, '0, 1'b0, 16'h0000, NO_RESULT, '0));
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'h0001, NO_RESULT, '0));
    dir_rows.push_back(mk_row(FUNC_FATAL, '0, '0, 1'b0, 16'h0000, NO_RESULT, '0));
    // empty read finishes at once
    dir_rows.push_back(mk_row(FUNC_REQ, '0, '0, 1'b0, '0, ONE_RESULT, done_word(1'b1)));
    dir_rows.push_back(mk_row(FUNC_REQ, 64'd5, 32'd3, 1'b0, '0, ONE_RESULT, first_cmd));
    // request while busy is dropped
    dir_rows.push_back(mk_row(FUNC_REQ, '1, '1, 1'b1, '0, NO_RESULT, '0));
    // stale phase bit
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'h0000, NO_RESULT, '0));
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'h0001, PREDICT, '0));
    // write crossing the top of the lba space
    dir_rows.push_back(mk_row(FUNC_REQ, 64'hFFFF_FFFF_FFFF_FFF8, 32'd40, 1'b1, '0,
                              PREDICT, '0));
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'h0001, PREDICT, '0));
    // error status ends the request with failure
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'hFFFF, PREDICT, '0));
    // empty write issues only the flush, whose error status is ignored
    dir_rows.push_back(mk_row(FUNC_REQ, '1, '0, 1'b1, '0, PREDICT, '0));
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'hFFFF, PREDICT, '0));
    // largest count, then a fatal abort
    dir_rows.push_back(mk_row(FUNC_REQ, '0, '1, 1'b0, '0, PREDICT, '0));
    dir_rows.push_back(mk_row(FUNC_TICK, '0, '0, 1'b0, '0, NO_RESULT, '0));
    dir_rows.push_back(mk_row(FUNC_FATAL, '0, '0, 1'b0, '0, ONE_RESULT, done_word(1'b0)));
    // single sector write, its flush, then fatal during the flush
    dir_rows.push_back(mk_row(FUNC_REQ, 64'hA5A5_5A5A_0F0F_F0F0, 32'd1, 1'b1, '0,
                              PREDICT, '0));
    dir_rows.push_back(mk_row(FUNC_CQE, '0, '0, 1'b0, 16'h0001, PREDICT, '0));
    dir_rows.push_back(mk_row(FUNC_TICK, '0, '0, 1'b0, '0, NO_RESULT, '0));
    dir_rows.push_back(mk_row(FUNC_FATAL, '0, '0, 1'b0, '0, ONE_RESULT, done_word(1'b1)));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].want);
    wait_for_quiet();

    // random phases, each under its own register setting
    for (int p = 1; p <= 7; p++) begin
      c.sector_shift = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(9, 12));
      c.max_chunk_sectors = 5'($urandom_range(0, 31));
      c.ns_id = $urandom;
      c.buffer_base = {$urandom, $urandom};
      c.timeout_ticks = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(1, 8));
      case (p)
        1: begin  // low corners, timeout limit of one tick
          c.sector_shift = 4'd12;
          c.max_chunk_sectors = 5'd1;
          c.ns_id = '0;
          c.buffer_base = '0;
          c.timeout_ticks = 16'd1;
        end
        2: begin  // high corners, prp2 wraps past the top of memory
          c.sector_shift = 4'd9;
          c.max_chunk_sectors = 5'd16;
          c.ns_id = '1;
          c.buffer_base = 64'hFFFF_FFFF_FFFF_F000;
          c.timeout_ticks = 16'hFFFF;
        end
        3: begin  // chunk of zero behaves as one
          c.sector_shift = 4'd0;
          c.max_chunk_sectors = 5'd0;
          c.timeout_ticks = 16'd3;
        end
        4: begin  // chunk above sixteen is clipped
          c.sector_shift = 4'd15;
          c.max_chunk_sectors = 5'd31;
          c.timeout_ticks = 16'd2;
        end
        default: ;
      endcase
      // idling pattern per phase; the last phase runs flat out
      tx_gaps_on = (p != 3) && (p != 4) && (p != 7);
      rx_stalls_on = (p != 3) && (p != 5) && (p != 7);

      set_reg(REG_SECTOR_SHIFT, 64'(c.sector_shift));
      set_reg(REG_MAX_CHUNK, 64'(c.max_chunk_sectors));
      set_reg(REG_NSID, 64'(c.ns_id));
      set_reg(REG_BUF_BASE, c.buffer_base);
      set_reg(REG_TIMEOUT, 64'(c.timeout_ticks));
      settings_used++;

      target = words_in + 150;
      while (words_in < target) begin
        // now and then the sender holds off until the engine has caught up
        if ($urandom_range(0, 99) == 0) wait_for_quiet();
        send_word(random_word(), PREDICT, '0);
      end
      if (p != 7) wait_for_quiet();
    end

    // end of stimulus: let the last words drain
    @(negedge clk);
    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && pending_words.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_words.size() != 0)
      flag_mismatch("words never delivered", pending_words.size(), '0);

    $display("run covered %0d input words (%0d acted on) over %0d register settings",
             words_in, busy_words, settings_used + 1);
    $display("checked %0d commands (%0d flushes), %0d doorbells, %0d done (%0d failed)",
             n_cmd, n_flush, n_db, n_done, n_failed);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
